>>> src/rss_pkg.sv
package rss_pkg;

   localparam int WORD_W         = 24;
   localparam int THRESH_W       = 25;
   localparam int COUNT_W        = 9;
   localparam int STATUS_W       = 2;
   localparam int BIT_SHIFT      = 6;
   localparam int WORD_INDEX_W   = WORD_W - BIT_SHIFT;
   localparam int STEP_W         = $clog2(WORD_W);
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = THRESH_W;
   localparam int MAX_WEIGHT_DEF = 256;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_VECTOR_LENGTH       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REJECTION_THRESHOLD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_WEIGHT          = 2'd2;

   localparam logic [WORD_W-1:0]   VECTOR_LENGTH_RST       = 24'd57637;
   localparam logic [THRESH_W-1:0] REJECTION_THRESHOLD_RST = 25'd16768705;
   localparam logic [COUNT_W-1:0]  SET_WEIGHT_RST          = 9'd131;

   localparam logic [STATUS_W-1:0] STATUS_REJECTED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NEW       = 2'd2;

   typedef struct packed {
      logic              rejected;
      logic [WORD_W-1:0] position;
   } cand_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_REDUCE,
      FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DONE
   } back_state_type;

endpackage

>>> src/rss_ram.sv
module rss_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/rss_front.sv
module rss_front import rss_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [WORD_W-1:0]   req_random_word,
   input  logic [WORD_W-1:0]   vector_length,
   input  logic [THRESH_W-1:0] rejection_threshold,
   input  logic                q_full,
   output logic                q_push,
   output cand_type            q_item
);

   front_state_type   state_ff, state_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic            accept;
   logic            rejected;
   logic            no_reduce;
   logic [WORD_W:0] trial;
   logic [WORD_W:0] modulus;
   logic [WORD_W:0] diff;
   logic            last_step;

   assign accept    = req_valid && !req_stall;
   assign rejected  = {1'b0, req_random_word} >= rejection_threshold;
   assign no_reduce = vector_length == '0;
   assign trial     = {rem_ff, word_ff[WORD_W-1]};
   assign modulus   = {1'b0, vector_length};
   assign diff      = trial - modulus;
   assign last_step = step_ff == STEP_W'(WORD_W - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FR_IDLE: begin
            if (accept && !rejected && !no_reduce) begin
               state_in = FR_REDUCE;
            end
         end
         FR_REDUCE: begin
            if (last_step) begin
               state_in = FR_PUSH;
            end
         end
         FR_PUSH: begin
            if (!q_full) begin
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall       = 1'b1;
      q_push          = 1'b0;
      q_item.rejected = 1'b0;
      q_item.position = rem_ff;
      case (state_ff)
         FR_IDLE: begin
            req_stall = q_full;
            q_push    = accept && (rejected || no_reduce);
            if (rejected) begin
               q_item.rejected = 1'b1;
               q_item.position = '0;
            end else begin
               q_item.position = req_random_word;
            end
         end
         FR_REDUCE: begin
            req_stall = 1'b1;
         end
         FR_PUSH: begin
            q_push = !q_full;
         end
         default: req_stall = 1'b1;
      endcase
   end

   // bit-serial restoring remainder
   always_comb begin
      word_in = word_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      if (state_ff == FR_IDLE && accept) begin
         word_in = req_random_word;
         rem_in  = '0;
         step_in = '0;
      end else if (state_ff == FR_REDUCE) begin
         word_in = {word_ff[WORD_W-2:0], 1'b0};
         rem_in  = (trial >= modulus) ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      word_ff <= word_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

endmodule

>>> src/rss_queue.sv
module rss_queue import rss_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  cand_type push_item,
   output logic     full,
   input  logic     pop,
   output cand_type pop_item,
   output logic     empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cand_type           entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   assign full     = fill_ff == CNT_W'(QUEUE_DEPTH);
   assign empty    = fill_ff == '0;
   assign pop_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> src/rss_back.sv
module rss_back import rss_pkg::*; #(
   parameter int MAX_WEIGHT = MAX_WEIGHT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [COUNT_W-1:0]      set_weight,
   input  logic                    q_empty,
   input  cand_type                q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [WORD_W-1:0]       rsp_position,
   output logic [WORD_INDEX_W-1:0] rsp_word_index,
   output logic [BIT_SHIFT-1:0]    rsp_bit_offset,
   output logic [COUNT_W-1:0]      rsp_collected,
   output logic                    rsp_set_complete
);

   localparam int AW = (MAX_WEIGHT > 1) ? $clog2(MAX_WEIGHT) : 1;

   back_state_type     state_ff, state_in;
   cand_type           item_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] scan_ff;
   logic               pend_ff;
   logic               dup_ff;

   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [WORD_W-1:0]       rsp_position_ff;
   logic [COUNT_W-1:0]      rsp_collected_ff;
   logic                    rsp_set_complete_ff;

   logic [COUNT_W-1:0] eff_weight;
   logic [COUNT_W-1:0] count_plus;
   logic               out_free;
   logic               scan_done;
   logic               store;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [WORD_W-1:0]  rd_data;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic               finish;

   always_comb begin
      eff_weight = set_weight;
      if (set_weight == '0) begin
         eff_weight = COUNT_W'(1);
      end else if (32'(set_weight) > MAX_WEIGHT) begin
         eff_weight = COUNT_W'(MAX_WEIGHT);
      end
   end

   assign count_plus = count_ff + 1'b1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign scan_done  = (scan_ff == count_ff) && !pend_ff;
   assign store      = !item_ff.rejected && !dup_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               state_in = q_item.rejected ? BK_DONE : BK_SCAN;
            end
         end
         BK_SCAN: begin
            if (scan_done) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop   = 1'b0;
      rd_en   = 1'b0;
      wr_en   = 1'b0;
      finish  = 1'b0;
      rd_addr = AW'(scan_ff);
      wr_addr = AW'(count_ff);
      case (state_ff)
         BK_IDLE: begin
            q_pop = !q_empty;
         end
         BK_SCAN: begin
            rd_en = scan_ff != count_ff;
         end
         BK_DONE: begin
            finish = out_free;
            wr_en  = out_free && store;
         end
         default: q_pop = 1'b0;
      endcase
   end

   rss_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_WEIGHT)
   ) u_index_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (item_ff.position),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= rd_en;
         if (q_pop) begin
            // a full set restarts when the next beat arrives
            count_ff <= (count_ff >= eff_weight) ? '0 : count_ff;
         end else if (wr_en) begin
            count_ff <= count_plus;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (q_pop) begin
         item_ff <= q_item;
         scan_ff <= '0;
         dup_ff  <= 1'b0;
      end else begin
         if (rd_en) begin
            scan_ff <= scan_ff + 1'b1;
         end
         if (pend_ff && rd_data == item_ff.position) begin
            dup_ff <= 1'b1;
         end
      end
      if (finish) begin
         if (item_ff.rejected) begin
            rsp_status_ff <= STATUS_REJECTED;
         end else if (dup_ff) begin
            rsp_status_ff <= STATUS_DUPLICATE;
         end else begin
            rsp_status_ff <= STATUS_NEW;
         end
         rsp_position_ff     <= item_ff.position;
         rsp_collected_ff    <= store ? count_plus : count_ff;
         rsp_set_complete_ff <= store && (count_plus >= eff_weight);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_word_index   = rsp_position_ff[WORD_W-1:BIT_SHIFT];
   assign rsp_bit_offset   = rsp_position_ff[BIT_SHIFT-1:0];
   assign rsp_collected    = rsp_collected_ff;
   assign rsp_set_complete = rsp_set_complete_ff;

endmodule

>>> src/rejection_support_sampler.sv
// Rejection sampler for the support of a fixed-weight sparse vector. Each req beat carries a
// 24-bit random word; each produces exactly one rsp beat with its status (rejected, duplicate,
// new), the position modulo vector_length, its 64-bit word index and bit offset, and the set
// count. A front end checks the threshold and reduces the word with a bit-serial remainder unit,
// one bit per cycle; a rejected word, or any word when vector_length is zero, goes to the queue
// without reduction. A two-entry queue feeds a back end that walks the stored indices of the
// current set through a single-port-read RAM, one index per cycle. Front and back overlap.
// Configuration writes take effect immediately and belong only where the block is idle.
module rejection_support_sampler import rss_pkg::*; #(
   parameter int MAX_WEIGHT = MAX_WEIGHT_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [WORD_W-1:0]       req_random_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [WORD_W-1:0]       rsp_position,
   output logic [WORD_INDEX_W-1:0] rsp_word_index,
   output logic [BIT_SHIFT-1:0]    rsp_bit_offset,
   output logic [COUNT_W-1:0]      rsp_collected,
   output logic                    rsp_set_complete
);

   logic [WORD_W-1:0]   vector_length_ff;
   logic [THRESH_W-1:0] rejection_threshold_ff;
   logic [COUNT_W-1:0]  set_weight_ff;

   logic     q_push;
   logic     q_pop;
   logic     q_full;
   logic     q_empty;
   cand_type q_push_item;
   cand_type q_pop_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff       <= VECTOR_LENGTH_RST;
         rejection_threshold_ff <= REJECTION_THRESHOLD_RST;
         set_weight_ff          <= SET_WEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VECTOR_LENGTH:       vector_length_ff       <= csr_wdata[WORD_W-1:0];
            CSR_REJECTION_THRESHOLD: rejection_threshold_ff <= csr_wdata[THRESH_W-1:0];
            CSR_SET_WEIGHT:          set_weight_ff          <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   rss_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_random_word     (req_random_word),
      .vector_length       (vector_length_ff),
      .rejection_threshold (rejection_threshold_ff),
      .q_full              (q_full),
      .q_push              (q_push),
      .q_item              (q_push_item)
   );

   rss_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .empty     (q_empty)
   );

   rss_back #(
      .MAX_WEIGHT (MAX_WEIGHT)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .set_weight       (set_weight_ff),
      .q_empty          (q_empty),
      .q_item           (q_pop_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_position     (rsp_position),
      .rsp_word_index   (rsp_word_index),
      .rsp_bit_offset   (rsp_bit_offset),
      .rsp_collected    (rsp_collected),
      .rsp_set_complete (rsp_set_complete)
   );

endmodule

>>> tb/rejection_support_sampler_test.sv
module rejection_support_sampler_test;
   import rss_pkg::*;

   localparam int MAX_W = MAX_WEIGHT_DEF;
   localparam int STALL_PCT = 13;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 300;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [WORD_W-1:0]       position;
      logic [WORD_INDEX_W-1:0] word_index;
      logic [BIT_SHIFT-1:0]    bit_offset;
      logic [COUNT_W-1:0]      collected;
      logic                    set_complete;
   } draw_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [WORD_W-1:0]       req_random_word = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic [WORD_W-1:0]       rsp_position;
   logic [WORD_INDEX_W-1:0] rsp_word_index;
   logic [BIT_SHIFT-1:0]    rsp_bit_offset;
   logic [COUNT_W-1:0]      rsp_collected;
   logic                    rsp_set_complete;

   // shadow of the register file and the current set
   logic [WORD_W-1:0]   cfg_length = VECTOR_LENGTH_RST;
   logic [THRESH_W-1:0] cfg_thresh = REJECTION_THRESHOLD_RST;
   logic [COUNT_W-1:0]  cfg_weight = SET_WEIGHT_RST;
   logic [WORD_W-1:0]   support_pos [MAX_W];
   int unsigned         support_cnt = 0;

   logic [WORD_W-1:0] words_pending [$];
   logic [WORD_W-1:0] recent_words [$];
   draw_result_type   draws_due [$];

   logic req_beat_done = 1'b0;
   int   tick = 0;
   int   stuck_cycles = 0;
   int   mismatches = 0;
   int   words_sent = 0;
   int   seen_rejected = 0;
   int   seen_duplicate = 0;
   int   seen_new = 0;
   int   seen_sets = 0;

   rejection_support_sampler u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_random_word  (req_random_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_position     (rsp_position),
      .rsp_word_index   (rsp_word_index),
      .rsp_bit_offset   (rsp_bit_offset),
      .rsp_collected    (rsp_collected),
      .rsp_set_complete (rsp_set_complete)
   );

   always #6 clock = ~clock;

   task automatic predict_draw(input logic [WORD_W-1:0] word, output draw_result_type res);
      int unsigned       weight;
      logic [WORD_W-1:0] pos;
      bit                dup;
      weight = (cfg_weight == 0) ? 1 : (cfg_weight > MAX_W) ? MAX_W : cfg_weight;
      res = '0;
      res.status = STATUS_REJECTED;
      if (support_cnt >= weight) support_cnt = 0;
      if ({1'b0, word} < cfg_thresh) begin
         pos = (cfg_length == 0) ? word : word % cfg_length;
         dup = 1'b0;
         for (int k = 0; k < support_cnt && k < MAX_W; k++) begin
            if (support_pos[k] == pos) dup = 1'b1;
         end
         if (dup) begin
            res.status = STATUS_DUPLICATE;
         end else begin
            res.status = STATUS_NEW;
            if (support_cnt < MAX_W) support_pos[support_cnt] = pos;
            support_cnt++;
            res.set_complete = (support_cnt >= weight);
         end
         res.position = pos;
         res.word_index = pos[WORD_W-1:BIT_SHIFT];
         res.bit_offset = pos[BIT_SHIFT-1:0];
      end
      res.collected = support_cnt[COUNT_W-1:0];
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t mismatch on %s: expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // monitor, predictor hookup and watchdog
   always @(posedge clock) begin
      draw_result_type got, want, fresh;
      if (reset) begin
         req_beat_done <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_position, rsp_word_index, rsp_bit_offset,
                    rsp_collected, rsp_set_complete};
            if (draws_due.size() == 0) begin
               $display("%0t unexpected rsp beat: status %0d position %0d",
                        $time, got.status, got.position);
               mismatches++;
            end else begin
               want = draws_due.pop_front();
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("position", 32'(want.position), 32'(got.position));
               check_field("word_index", 32'(want.word_index), 32'(got.word_index));
               check_field("bit_offset", 32'(want.bit_offset), 32'(got.bit_offset));
               check_field("collected", 32'(want.collected), 32'(got.collected));
               check_field("set_complete", 32'(want.set_complete),
                           32'(got.set_complete));
               case (want.status)
                  STATUS_REJECTED:  seen_rejected++;
                  STATUS_DUPLICATE: seen_duplicate++;
                  default:          seen_new++;
               endcase
               if (want.set_complete) seen_sets++;
            end
         end
         if (req_valid && !req_stall) begin
            predict_draw(words_pending.pop_front(), fresh);
            draws_due.push_back(fresh);
            words_sent++;
         end
         req_beat_done <= req_valid && !req_stall;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t timeout, %0d words pending, %0d results due", $time,
                        words_pending.size(), draws_due.size());
               $display("TB_ERROR");
               $finish;
            end
         end
      end
   end

   // driver and response backpressure
   always @(negedge clock) begin
      logic next_valid;
      logic calm;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         tick++;
         calm = (tick % 3000) < 800;
         if (req_valid && !req_beat_done) begin
            next_valid = 1'b1;
         end else begin
            next_valid = (words_pending.size() != 0) &&
                         (calm || $urandom_range(99) >= STALL_PCT);
         end
         req_valid <= next_valid;
         if (next_valid) req_random_word <= words_pending[0];
         rsp_stall <= !calm && ($urandom_range(99) < STALL_PCT);
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_VECTOR_LENGTH:       cfg_length = data[WORD_W-1:0];
         CSR_REJECTION_THRESHOLD: cfg_thresh = data;
         CSR_SET_WEIGHT:          cfg_weight = data[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_registers(input logic [CSR_DATA_W-1:0] length,
                                input logic [CSR_DATA_W-1:0] thresh,
                                input logic [CSR_DATA_W-1:0] weight);
      write_csr(CSR_VECTOR_LENGTH, length);
      write_csr(CSR_REJECTION_THRESHOLD, thresh);
      write_csr(CSR_SET_WEIGHT, weight);
   endtask

   function automatic logic [CSR_DATA_W-1:0] exact_multiple(input longint n);
      return CSR_DATA_W'(((64'd1 << WORD_W) / n) * n);
   endfunction

   task automatic push_word(input logic [WORD_W-1:0] w);
      words_pending.push_back(w);
      recent_words.push_back(w);
      if (recent_words.size() > 64) void'(recent_words.pop_front());
   endtask

   // mostly words under the threshold, some repeats for duplicates, some raw noise
   task automatic fill_random(input int count);
      logic [WORD_W-1:0] w;
      longint unsigned   span;
      int                pick;
      span = (cfg_thresh > (1 << WORD_W)) ? (64'd1 << WORD_W) : cfg_thresh;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 15 || span == 0) begin
            w = WORD_W'($urandom);
         end else if (pick < 27 && recent_words.size() != 0) begin
            w = recent_words[$urandom_range(recent_words.size() - 1)];
         end else begin
            w = WORD_W'($urandom_range(32'(span - 1), 0));
         end
         push_word(w);
      end
   endtask

   task automatic wait_drained();
      while (words_pending.size() != 0 || draws_due.size() != 0 || req_valid) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset settings, field extremes and each outcome
      push_word('0);
      push_word('1);
      push_word(24'd16768704);
      push_word(24'd16768705);
      push_word(24'd57637);
      push_word(24'd57636);
      push_word(24'd63);
      push_word(24'd64);
      push_word(24'hAAAAAA);
      push_word(24'h555555);
      push_word(24'd115279);
      push_word(24'd5);
      push_word(24'd16768704);
      fill_random(300);
      wait_drained();

      // smallest length, one index per set, nothing rejected
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom));
      set_registers(2, 1 << WORD_W, 1);
      fill_random(100);
      wait_drained();

      // largest length and full-size sets
      set_registers(24'hFFFFFF, 24'hFFFFFF, MAX_W);
      push_word(24'hFFFFFE);
      push_word(24'hFFFFFF);
      fill_random(300);
      wait_drained();

      // zero length skips reduction, zero weight acts as one, no threshold
      set_registers(0, 25'h1FFFFFF, 0);
      push_word('1);
      fill_random(100);
      wait_drained();

      // oversize weight clamps, short modulus gives many duplicates
      set_registers(37, exact_multiple(37), 511);
      fill_random(300);
      wait_drained();

      // lower weight than the count left over from the last set
      set_registers(1000, exact_multiple(1000), 20);
      fill_random(300);
      wait_drained();

      // tight threshold, most noise is rejected
      set_registers(7, 4096, 7);
      fill_random(200);
      wait_drained();

      set_registers(VECTOR_LENGTH_RST, REJECTION_THRESHOLD_RST, SET_WEIGHT_RST);
      fill_random(350);
      wait_drained();

      $display("sent %0d random words over 8 register settings, %0d mismatches",
               words_sent, mismatches);
      $display("outcomes: %0d rejected, %0d duplicate, %0d new index, %0d full sets",
               seen_rejected, seen_duplicate, seen_new, seen_sets);
      if (mismatches == 0 && draws_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
